>>> hw/rtl/bb3_pkg.sv
package bb3_pkg;

  localparam int MAX_DIM_DEF = 1024;
  localparam int RESET_DIM   = 512;
  localparam int CFG_W       = 11;
  localparam int COMP_W      = 16;
  localparam int PIX_W       = 3 * COMP_W;
  localparam int POS_W       = 10;
  localparam int SUM_W       = 20;
  localparam int CNT_W       = 4;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SH    = 24;
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef struct packed {
    logic [COMP_W-1:0] red_in;
    logic [COMP_W-1:0] green_in;
    logic [COMP_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_col;
    logic [COMP_W-1:0] red_out;
    logic [COMP_W-1:0] green_out;
    logic [COMP_W-1:0] blue_out;
    logic              run_end;
    logic              frame_end;
  } out_item_t;

  typedef struct packed {
    logic [COMP_W-1:0] r;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] b;
  } pix_t;

  // ceil(2^24 / n): exact truncating quotient for sums below 2^20
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    unique case (n)
      4'd2:    m = 25'd8388608;
      4'd3:    m = 25'd5592406;
      4'd4:    m = 25'd4194304;
      4'd6:    m = 25'd2796203;
      4'd9:    m = 25'd1864136;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/bb3_ram.sv
module bb3_ram #(
  parameter int WIDTH = bb3_pkg::PIX_W,
  parameter int DEPTH = bb3_pkg::MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/box_blur_3x3_rgb_top.sv
// Items pass the window stage, the sum stage and the output register. Throughput: one
// item per cycle while items give at most one result and the output does not stall; an
// item holds the window stage until its last result issues. The window stage, emitting
// one result per cycle while the sum stage is free, sets that rate.
// Reset (synchronous, rst_n low) clears all valid flags and the row/column position
// and sets the dimension to 512 (MAX_DIM if smaller); line memories are not cleared.
module box_blur_3x3_rgb_top #(
  parameter int MAX_DIM = bb3_pkg::MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bb3_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bb3_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [bb3_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {
    SLOT_UL = 2'd0,
    SLOT_UR = 2'd1,
    SLOT_LL = 2'd2,
    SLOT_LR = 2'd3
  } slot_t;

  // configuration and position
  logic [DW-1:0] dim_r, dim_nxt;
  logic [AW-1:0] row_r, row_nxt;
  logic [AW-1:0] col_r, col_nxt;

  // window stage
  logic            s1_v_r, s1_v_nxt;
  bb3_pkg::pix_t   s1_px_r;
  logic [AW-1:0]   s1_row_r;
  logic [AW-1:0]   s1_col_r;
  logic            s1_rge1_r, s1_rge2_r, s1_cge1_r, s1_cge2_r;
  logic [3:0]      pend_r, pend_nxt;
  logic            fwd_r;
  bb3_pkg::pix_t   fwd_old_r, fwd_new_r;
  bb3_pkg::pix_t   win_r [6];

  // sum stage
  logic                      s2_v_r;
  logic [bb3_pkg::POS_W-1:0] s2_row_r, s2_col_r;
  logic [bb3_pkg::SUM_W-1:0] s2_sr_r, s2_sg_r, s2_sb_r;
  logic [bb3_pkg::CNT_W-1:0] s2_cnt_r;
  logic                      s2_run_r, s2_frame_r;

  // output register
  logic                out_v_r;
  bb3_pkg::out_item_t  out_r;

  logic acc, s3_free, s2_free, issue, s1_done, run_last;
  logic [bb3_pkg::PIX_W-1:0] older_rd, newer_rd;
  bb3_pkg::pix_t older_eff, newer_eff;
  bb3_pkg::pix_t grid [3][3];
  slot_t         sel;
  logic [3:0]    sel_oh;
  logic [3:0]    pend_left;
  logic          upper, left;
  logic [2:0]    rm, cm;
  logic [1:0]    nr, nc;
  logic [bb3_pkg::CNT_W-1:0] cnt;
  logic [bb3_pkg::SUM_W-1:0] sr, sg, sb;
  logic [AW-1:0] orow, ocol;
  logic [DW-1:0] col_inc, row_inc;
  logic [bb3_pkg::PROD_W-1:0] pr, pg, pb;
  logic [bb3_pkg::RECIP_W-1:0] rcp;

  // handshake
  assign s3_free  = !out_v_r || !out_stall;
  assign s2_free  = !s2_v_r || s3_free;
  assign issue    = s1_v_r && (pend_r != 4'd0) && s2_free;
  assign run_last = (pend_left == 4'd0);
  assign s1_done  = s1_v_r && ((pend_r == 4'd0) || (issue && run_last));
  assign in_stall = s1_v_r && !s1_done;
  assign acc      = in_valid && !in_stall;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // line memories
  bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(MAX_DIM)) u_older (
    .clk     (clk),
    .wr_en   (s1_done),
    .wr_addr (s1_col_r),
    .wr_data (newer_eff),
    .rd_en   (acc),
    .rd_addr (col_r),
    .rd_data (older_rd)
  );

  bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(MAX_DIM)) u_newer (
    .clk     (clk),
    .wr_en   (s1_done),
    .wr_addr (s1_col_r),
    .wr_data (s1_px_r),
    .rd_en   (acc),
    .rd_addr (col_r),
    .rd_data (newer_rd)
  );

  assign older_eff = fwd_r ? fwd_old_r : bb3_pkg::pix_t'(older_rd);
  assign newer_eff = fwd_r ? fwd_new_r : bb3_pkg::pix_t'(newer_rd);

  // grid: rows k (oldest first), columns m (oldest first)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      grid[k][0] = win_r[2*k];
      grid[k][1] = win_r[2*k+1];
    end
    grid[0][2] = older_eff;
    grid[1][2] = newer_eff;
    grid[2][2] = s1_px_r;
  end

  // pick next pending result
  always_comb begin
    priority if (pend_r[SLOT_UL]) begin
      sel = SLOT_UL;
    end else if (pend_r[SLOT_UR]) begin
      sel = SLOT_UR;
    end else if (pend_r[SLOT_LL]) begin
      sel = SLOT_LL;
    end else begin
      sel = SLOT_LR;
    end
    sel_oh    = 4'd1 << sel;
    pend_left = pend_r & ~sel_oh;
  end

  // clipped neighborhood and sums
  always_comb begin
    upper = (sel == SLOT_UL) || (sel == SLOT_UR);
    left  = (sel == SLOT_UL) || (sel == SLOT_LL);
    rm    = upper ? {1'b1, 1'b1, s1_rge2_r} : {1'b1, s1_rge1_r, 1'b0};
    cm    = left  ? {1'b1, 1'b1, s1_cge2_r} : {1'b1, s1_cge1_r, 1'b0};
    nr    = 2'(rm[0]) + 2'(rm[1]) + 2'(rm[2]);
    nc    = 2'(cm[0]) + 2'(cm[1]) + 2'(cm[2]);
    cnt   = bb3_pkg::CNT_W'(nr) * bb3_pkg::CNT_W'(nc);
    orow  = upper ? s1_row_r - AW'(1) : s1_row_r;
    ocol  = left  ? s1_col_r - AW'(1) : s1_col_r;
    sr    = '0;
    sg    = '0;
    sb    = '0;
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        if (rm[k] && cm[m]) begin
          sr = sr + bb3_pkg::SUM_W'(grid[k][m].r);
          sg = sg + bb3_pkg::SUM_W'(grid[k][m].g);
          sb = sb + bb3_pkg::SUM_W'(grid[k][m].b);
        end
      end
    end
  end

  // position and configuration
  always_comb begin
    dim_nxt = dim_r;
    row_nxt = row_r;
    col_nxt = col_r;
    col_inc = DW'(col_r) + DW'(1);
    row_inc = DW'(row_r) + DW'(1);
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        dim_nxt = DW'(1);
      end else if (32'(cfg_wdata) > 32'(MAX_DIM)) begin
        dim_nxt = DW'(MAX_DIM);
      end else begin
        dim_nxt = DW'(cfg_wdata);
      end
      row_nxt = '0;
      col_nxt = '0;
    end else if (acc) begin
      if (col_inc >= dim_r) begin
        col_nxt = '0;
        row_nxt = (row_inc >= dim_r) ? '0 : row_r + AW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    pend_nxt = pend_r;
    if (acc) begin
      s1_v_nxt = 1'b1;
      pend_nxt[SLOT_UL] = (row_r != '0) && (col_r != '0);
      pend_nxt[SLOT_UR] = (row_r != '0) && (col_inc == dim_r);
      pend_nxt[SLOT_LL] = (row_inc == dim_r) && (col_r != '0);
      pend_nxt[SLOT_LR] = (row_inc == dim_r) && (col_inc == dim_r);
    end else if (s1_done) begin
      s1_v_nxt = 1'b0;
      pend_nxt = '0;
    end else if (issue) begin
      pend_nxt = pend_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r   <= DW'((bb3_pkg::RESET_DIM > MAX_DIM) ? MAX_DIM : bb3_pkg::RESET_DIM);
      row_r   <= '0;
      col_r   <= '0;
      s1_v_r  <= 1'b0;
      pend_r  <= '0;
      fwd_r   <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      dim_r  <= dim_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      s1_v_r <= s1_v_nxt;
      pend_r <= pend_nxt;
      if (acc) begin
        fwd_r <= s1_done && (s1_col_r == col_r);
      end
      if (s2_free) begin
        s2_v_r <= issue;
      end
      if (s3_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // window stage payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px_r   <= bb3_pkg::pix_t'(in_data);
      s1_row_r  <= row_r;
      s1_col_r  <= col_r;
      s1_rge1_r <= (row_r != '0);
      s1_rge2_r <= (row_r > AW'(1));
      s1_cge1_r <= (col_r != '0);
      s1_cge2_r <= (col_r > AW'(1));
      fwd_old_r <= newer_eff;
      fwd_new_r <= s1_px_r;
    end
    if (s1_done) begin
      for (int k = 0; k < 3; k++) begin
        win_r[2*k]   <= win_r[2*k+1];
        win_r[2*k+1] <= grid[k][2];
      end
    end
  end

  // sum stage payload
  always_ff @(posedge clk) begin
    if (issue) begin
      s2_row_r   <= bb3_pkg::POS_W'(orow);
      s2_col_r   <= bb3_pkg::POS_W'(ocol);
      s2_sr_r    <= sr;
      s2_sg_r    <= sg;
      s2_sb_r    <= sb;
      s2_cnt_r   <= cnt;
      s2_run_r   <= run_last;
      s2_frame_r <= (sel == SLOT_LR);
    end
  end

  // divide by neighbor count through reciprocal
  always_comb begin
    rcp = bb3_pkg::recip(s2_cnt_r);
    pr  = bb3_pkg::PROD_W'(s2_sr_r) * bb3_pkg::PROD_W'(rcp);
    pg  = bb3_pkg::PROD_W'(s2_sg_r) * bb3_pkg::PROD_W'(rcp);
    pb  = bb3_pkg::PROD_W'(s2_sb_r) * bb3_pkg::PROD_W'(rcp);
  end

  always_ff @(posedge clk) begin
    if (s3_free && s2_v_r) begin
      out_r.out_row   <= s2_row_r;
      out_r.out_col   <= s2_col_r;
      out_r.red_out   <= pr[bb3_pkg::RECIP_SH +: bb3_pkg::COMP_W];
      out_r.green_out <= pg[bb3_pkg::RECIP_SH +: bb3_pkg::COMP_W];
      out_r.blue_out  <= pb[bb3_pkg::RECIP_SH +: bb3_pkg::COMP_W];
      out_r.run_end   <= s2_run_r;
      out_r.frame_end <= s2_frame_r;
    end
  end

endmodule

>>> hw/rtl/bb3_checker.sv
module bb3_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bb3_pkg::out_item_t out_data
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("valid or stall not cleared by reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.run_end)
    else $error("frame end not on last result of its item");

  a_frame_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.out_row == out_data.out_col)
    else $error("frame end off the bottom-right corner");

endmodule

bind box_blur_3x3_rgb_top bb3_checker u_bb3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
